FILE: design/swtm_pkg.sv
// ----------------------------------------------------------------------------
// swtm_pkg
// Shared widths and constants of the sliding-window trimmed mean.
// ----------------------------------------------------------------------------
package swtm_pkg;
  localparam int WindowMax  = 64;
  localparam int SampleBits = 16;
  localparam int IdxBits    = $clog2(WindowMax);
  localparam int CntBits    = $clog2(WindowMax + 1);
  localparam int SumBits    = SampleBits + IdxBits;
  localparam int LenBits    = 7;
  localparam int TrimBits   = 5;
  localparam int CfgBits    = 7;
  localparam int CfgIdxBits = 1;
  localparam logic [CfgIdxBits-1:0] RegWindowLength = 1'd0;
  localparam logic [CfgIdxBits-1:0] RegTrimCount    = 1'd1;

  typedef logic [SampleBits-1:0] sample_t;

  // shared command to every cell of the sorted row
  typedef struct packed {
    logic    rm_en;
    sample_t rm_val;
    logic    ins_en;
    sample_t ins_val;
  } cell_cmd_t;
endpackage

FILE: design/swtm_if.sv
// ----------------------------------------------------------------------------
// swtm_in_if / swtm_out_if
// Valid/ready channels for samples and results.
// ----------------------------------------------------------------------------
interface swtm_in_if;
  logic               valid;
  logic               ready;
  swtm_pkg::sample_t  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swtm_out_if;
  logic               valid;
  logic               ready;
  swtm_pkg::sample_t  trimmed_mean;
  logic               full_res;
  modport source (output valid, output trimmed_mean, output full_res, input ready);
  modport sink   (input valid, input trimmed_mean, input full_res, output ready);
endinterface

FILE: design/swtm_cell.sv
// ----------------------------------------------------------------------------
// swtm_cell
// One slot of the sorted row: removes then inserts before its value register loads.
// ----------------------------------------------------------------------------
module swtm_cell (
  input  logic                clk,
  input  swtm_pkg::cell_cmd_t cmd,
  input  logic                occ,
  input  swtm_pkg::sample_t   left_val,
  input  swtm_pkg::sample_t   right_val,
  input  logic                right_occ,
  input  logic                left_gone,
  input  logic                left_ins_lt,
  output logic                gone_out,
  output logic                ins_lt_out,
  output swtm_pkg::sample_t   val
);
  swtm_pkg::sample_t val_r, val_nxt;
  swtm_pkg::sample_t mid_val, mid_left;
  logic mid_occ, hit, gone;

  // removal: first equal entry is dropped, entries to its right move left
  assign hit      = cmd.rm_en && occ && (val_r == cmd.rm_val);
  assign gone     = left_gone | hit;
  assign gone_out = gone;
  assign mid_val  = gone ? right_val : val_r;
  assign mid_occ  = gone ? right_occ : occ;
  // the left neighbor's post-removal value: left shifts only if it was gone too
  assign mid_left = left_gone ? val_r : left_val;

  // insertion: entries below new value stay, first not-below gets it, rest shift right
  assign ins_lt_out = mid_occ && (mid_val < cmd.ins_val);

  always_comb begin
    val_nxt = val_r;
    if (cmd.rm_en) val_nxt = mid_val;
    if (cmd.ins_en && !(mid_occ && mid_val < cmd.ins_val)) begin
      if (left_ins_lt) val_nxt = cmd.ins_val;
      else             val_nxt = mid_left;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end
  assign val = val_r;
endmodule

FILE: design/swtm_div.sv
// ----------------------------------------------------------------------------
// swtm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swtm_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [swtm_pkg::SumBits-1:0]       dividend,
  input  logic [swtm_pkg::CntBits-1:0]       divisor,
  output logic                               done,
  output logic [swtm_pkg::SampleBits-1:0]    quotient
);
  localparam int SB = swtm_pkg::SumBits;
  localparam int StepBits = $clog2(SB + 1);
  logic [SB-1:0] q_r, q_nxt;
  logic [swtm_pkg::CntBits-1:0] rem_r, rem_nxt, d_r;
  logic [swtm_pkg::CntBits:0] trial;
  logic [StepBits-1:0] step_r, step_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;

  assign trial = {rem_r, q_r[SB-1]};

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; step_nxt = step_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; step_nxt = StepBits'(SB); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = swtm_pkg::CntBits'(trial - {1'b0, d_r});
        q_nxt   = {q_r[SB-2:0], 1'b1};
      end else begin
        rem_nxt = trial[swtm_pkg::CntBits-1:0];
        q_nxt   = {q_r[SB-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == StepBits'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; step_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; step_r <= step_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (start) d_r <= divisor;
  end
  assign done = done_r;
  assign quotient = q_r[swtm_pkg::SampleBits-1:0];
endmodule

FILE: design/swtm_ram.sv
// ----------------------------------------------------------------------------
// swtm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module swtm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

FILE: design/sliding_window_trimmed_mean.sv
// ----------------------------------------------------------------------------
// sliding_window_trimmed_mean
// Trimmed mean over a sliding window kept in a row of sorting cells.
// ----------------------------------------------------------------------------
// channel | dir | handshake     | payload
// in      | in  | valid/ready   | sample[15:0]
// out     | out | valid/ready   | trimmed_mean[15:0], full_res
// cfg     | in  | write enable  | cfg_index[0:0], cfg_data[6:0]
// A full-window item with 2*trim < len goes from accept through ring write,
// cell row, middle sum of keep entries (keep = len - 2*trim), 22 divide steps,
// divider done and output load; other items skip sum and divide. The next item
// is accepted in the idle state after the load; a waiting result stalls the
// load. Reset is synchronous and clears control state only; ring and cells are
// only read where written. A register write empties the window.
// ----------------------------------------------------------------------------
module sliding_window_trimmed_mean (
  input  logic                 clk,
  input  logic                 rst_n,
  swtm_in_if.sink              in_ch,
  swtm_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [swtm_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [swtm_pkg::CfgBits-1:0]    cfg_data
);
  localparam int W  = swtm_pkg::WindowMax;
  localparam int IB = swtm_pkg::IdxBits;
  localparam int CB = swtm_pkg::CntBits;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_READ = 6'b000010, S_CELL = 6'b000100,
    S_SUM  = 6'b001000, S_DIV  = 6'b010000, S_OUT  = 6'b100000
  } state_t;
  state_t state_r, state_nxt;

  logic [swtm_pkg::LenBits-1:0]  wlen_r;
  logic [swtm_pkg::TrimBits-1:0] trim_r;
  logic [IB-1:0] old_pos_r, wr_pos_r;
  logic [CB-1:0] fill_r, len, keep;
  logic [W-1:0]  occ_r;
  swtm_pkg::sample_t samp_r;
  logic [swtm_pkg::SumBits-1:0] sum_r;
  logic [IB-1:0] sidx_r;
  logic [CB-1:0] scnt_r;
  logic ok;
  logic ovalid_r;
  swtm_pkg::sample_t omean_r;
  logic ofull_r;

  // effective length saturates into 3..WindowMax
  always_comb begin
    if (wlen_r < 7'd3) len = CB'(3);
    else if (wlen_r > 7'(W)) len = CB'(W);
    else len = CB'(wlen_r);
  end
  assign ok   = ({1'b0, trim_r, 1'b0} < 7'(len));
  assign keep = len - CB'({trim_r, 1'b0});

  // arrival ring
  swtm_pkg::sample_t ring_q;
  logic ring_we;
  logic [IB-1:0] ring_addr;
  assign ring_we   = (state_r == S_READ);
  assign ring_addr = ring_we ? wr_pos_r : old_pos_r;
  swtm_ram #(.Width(swtm_pkg::SampleBits), .Depth(W)) u_ring (
    .clk(clk), .we(ring_we), .addr(ring_addr), .wdata(samp_r), .rdata(ring_q));
  // read of old_pos happens in S_IDLE accept cycle; ring_q valid in S_READ,
  // but write uses port in S_READ, so capture old value there
  swtm_pkg::sample_t old_r;
  logic full_now;
  assign full_now = (fill_r == len);

  // sorted cell row
  swtm_pkg::cell_cmd_t cmd;
  swtm_pkg::sample_t cval [W];
  logic [W:0] gone_c, lt_c;
  assign cmd.rm_en   = (state_r == S_CELL) && full_now;
  assign cmd.rm_val  = old_r;
  assign cmd.ins_en  = (state_r == S_CELL);
  assign cmd.ins_val = samp_r;
  assign gone_c[0] = 1'b0;
  assign lt_c[0]   = 1'b1;
  for (genvar g = 0; g < W; g++) begin : g_cell
    swtm_cell u_cell (
      .clk(clk), .cmd(cmd), .occ(occ_r[g]),
      .left_val(g == 0 ? samp_r : cval[(g == 0) ? 0 : g-1]),
      .right_val(g == W-1 ? samp_r : cval[(g == W-1) ? g : g+1]),
      .right_occ(g == W-1 ? 1'b0 : occ_r[(g == W-1) ? g : g+1]),
      .left_gone(gone_c[g]), .left_ins_lt(lt_c[g]),
      .gone_out(gone_c[g+1]), .ins_lt_out(lt_c[g+1]), .val(cval[g]));
  end

  // divider
  logic div_done;
  swtm_pkg::sample_t div_q;
  swtm_div u_div (.clk(clk), .rst_n(rst_n), .start(state_r == S_SUM && scnt_r == '0),
    .dividend(sum_r), .divisor(keep), .done(div_done), .quotient(div_q));

  assign in_ch.ready = (state_r == S_IDLE) && !cfg_we;
  assign out_ch.valid = ovalid_r;
  assign out_ch.trimmed_mean = omean_r;
  assign out_ch.full_res = ofull_r;

  logic ofree;
  assign ofree = !ovalid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_nxt = S_READ;
      S_READ: state_nxt = S_CELL;
      S_CELL: state_nxt = (full_now || fill_r == len - 1'b1) && ok ? S_SUM : S_OUT;
      S_SUM:  if (scnt_r == '0) state_nxt = S_DIV;
      S_DIV:  if (div_done) state_nxt = S_OUT;
      S_OUT:  if (ofree) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic valid_res_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; wlen_r <= 7'd3; trim_r <= 5'd1;
      old_pos_r <= '0; wr_pos_r <= '0; fill_r <= '0; occ_r <= '0;
      ovalid_r <= 1'b0; sum_r <= '0; valid_res_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // output register: load a new result, or drop the one just taken
      if (state_r == S_OUT && ofree) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == swtm_pkg::RegWindowLength) wlen_r <= cfg_data;
        if (cfg_index == swtm_pkg::RegTrimCount)
          trim_r <= cfg_data[swtm_pkg::TrimBits-1:0];
        old_pos_r <= '0; wr_pos_r <= '0; fill_r <= '0; occ_r <= '0;
      end
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          samp_r <= in_ch.sample;
        end
        S_READ: begin
          old_r <= ring_q;
          wr_pos_r <= (CB'(wr_pos_r) + 1'b1 >= len) ? '0 : wr_pos_r + 1'b1;
        end
        S_CELL: begin
          if (full_now)
            old_pos_r <= (CB'(old_pos_r) + 1'b1 >= len) ? '0 : old_pos_r + 1'b1;
          else begin
            fill_r <= fill_r + 1'b1;
            occ_r[fill_r[IB-1:0]] <= 1'b1;
          end
          sum_r <= '0;
          sidx_r <= IB'(trim_r);
          scnt_r <= keep;
          valid_res_r <= (full_now || fill_r == len - 1'b1) && ok;
        end
        S_SUM: if (scnt_r != '0) begin
          sum_r <= sum_r + swtm_pkg::SumBits'(cval[sidx_r]);
          sidx_r <= sidx_r + 1'b1;
          scnt_r <= scnt_r - 1'b1;
        end
        S_OUT: if (ofree) begin
          omean_r <= valid_res_r ? div_q : '0;
          ofull_r <= valid_res_r;
        end
        default: ;
      endcase
    end
  end

  // fill count never exceeds the window
  a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CB'(W))
    else $error("fill overflow");
  // no input accepted outside idle
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> state_r == S_IDLE) else $error("accept");
  // a flagged result carries a full window
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && ofree && valid_res_r) |-> fill_r == len) else $error("flag");
endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the sliding-window trimmed mean against a behavioral model kept in
// the bench. The model tracks the window as an arrival-order queue, sorts a
// copy per item, and predicts mean and full flag for every accepted sample.
// Both sides stall at random. Register writes happen only while the block is
// idle, and the run steps through several window and trim settings.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles   = 150;
  localparam int IdlePct       = 29;

  typedef struct packed {
    swtm_pkg::sample_t mean;
    logic              full;
  } mean_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [swtm_pkg::CfgIdxBits-1:0] cfg_index;
  logic [swtm_pkg::CfgBits-1:0]    cfg_data;

  swtm_in_if  in_ch ();
  swtm_out_if out_ch ();

  sliding_window_trimmed_mean u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // model state
  logic [swtm_pkg::LenBits-1:0]  window_len_reg;
  logic [swtm_pkg::TrimBits-1:0] trim_reg;
  swtm_pkg::sample_t   window_q[$];
  swtm_pkg::sample_t   pending_samples[$];
  mean_result_t        expected_means[$];
  int                  error_count;
  bit                  no_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Window size actually used by the block
  function automatic int eff_len();
    int n;
    n = window_len_reg;
    if (n < 3) n = 3;
    if (n > swtm_pkg::WindowMax) n = swtm_pkg::WindowMax;
    return n;
  endfunction

  // Slide the window by one sample and queue the expected mean
  function automatic void predict_mean(swtm_pkg::sample_t s);
    swtm_pkg::sample_t sorted_copy[$];
    int           len;
    int           k;
    longint       acc;
    mean_result_t r;
    len = eff_len();
    k = trim_reg;
    window_q.push_back(s);
    if (window_q.size() > len) void'(window_q.pop_front());
    r = '0;
    if (window_q.size() == len && 2 * k < len) begin
      sorted_copy = window_q;
      sorted_copy.sort();
      acc = 0;
      for (int i = k; i < len - k; i++) acc += sorted_copy[i];
      r.mean = swtm_pkg::sample_t'(acc / (len - 2 * k));
      r.full = 1'b1;
    end
    expected_means.push_back(r);
  endfunction

  // Sample driver
  always @(posedge clk) begin
    logic fire;
    logic nxt_valid;
    swtm_pkg::sample_t nxt_sample;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      in_ch.sample <= '0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      nxt_valid = in_ch.valid;
      nxt_sample = in_ch.sample;
      if (fire) begin
        predict_mean(in_ch.sample);
        void'(pending_samples.pop_front());
      end
      if (!in_ch.valid || fire) begin
        if (pending_samples.size() > 0 &&
            (no_idle || $urandom_range(99) >= IdlePct)) begin
          nxt_valid = 1'b1;
          nxt_sample = pending_samples[0];
        end else begin
          nxt_valid = 1'b0;
        end
      end
      in_ch.valid  <= nxt_valid;
      in_ch.sample <= nxt_sample;
    end
  end

  // Result monitor and backpressure
  always @(posedge clk) begin
    mean_result_t exp_r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_means.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("ERROR: unexpected result mean=%0d full=%0b",
                     out_ch.trimmed_mean, out_ch.full_res);
        end else begin
          exp_r = expected_means.pop_front();
          if (out_ch.trimmed_mean !== exp_r.mean || out_ch.full_res !== exp_r.full) begin
            error_count++;
            if (error_count <= 10)
              $display("ERROR: mean exp=%0d got=%0d, full exp=%0b got=%0b",
                       exp_r.mean, out_ch.trimmed_mean, exp_r.full, out_ch.full_res);
          end
        end
      end
      out_ch.ready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    int quiet;
    if (!rst_n) begin
      quiet = 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Write one register while idle; any write empties the window
  task automatic write_reg(logic [swtm_pkg::CfgIdxBits-1:0] idx,
                           logic [swtm_pkg::CfgBits-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == swtm_pkg::RegWindowLength) window_len_reg = val[swtm_pkg::LenBits-1:0];
    else trim_reg = val[swtm_pkg::TrimBits-1:0];
    window_q.delete();
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || expected_means.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic swtm_pkg::sample_t rand_sample();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'hFFFF;
    if (pick == 1) return 16'h0000;
    if (pick < 5) return swtm_pkg::sample_t'($urandom_range(7));
    return swtm_pkg::sample_t'($urandom);
  endfunction

  // Stimulus phases
  initial begin
    int lens[8];
    int trims[8];
    int counts[8];
    int len_pick;
    int trim_pick;
    lens   = '{0, 2, 64, 127, 5, 10, 64, 8};
    trims  = '{0, 1, 31, 31, 3, 0, 20, 2};
    counts = '{60, 60, 200, 150, 60, 80, 150, 80};
    error_count = 0;
    no_idle = 1'b0;
    window_len_reg = swtm_pkg::LenBits'(3);
    trim_reg = swtm_pkg::TrimBits'(1);
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset setting, extremes, ties and alternating bits
    pending_samples = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF,
                        16'h0000, 16'h0001, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF,
                        16'h0000, 16'h1234, 16'h1234, 16'h1234};
    wait_idle();

    // fixed settings: saturation, zero trim, oversized trim, max window
    for (int p = 0; p < 8; p++) begin
      write_reg(swtm_pkg::RegWindowLength, swtm_pkg::CfgBits'(lens[p]));
      write_reg(swtm_pkg::RegTrimCount, swtm_pkg::CfgBits'(trims[p]));
      no_idle = (p == 2);
      for (int i = 0; i < counts[p]; i++) pending_samples.push_back(rand_sample());
      wait_idle();
    end
    no_idle = 1'b0;

    // random settings, mostly small windows
    for (int p = 0; p < 6; p++) begin
      len_pick = (p == 5) ? $urandom_range(127) : $urandom_range(16);
      trim_pick = $urandom_range(p == 5 ? 31 : 8);
      write_reg(swtm_pkg::RegWindowLength, swtm_pkg::CfgBits'(len_pick));
      write_reg(swtm_pkg::RegTrimCount, swtm_pkg::CfgBits'(trim_pick));
      for (int i = 0; i < 70; i++) pending_samples.push_back(rand_sample());
      wait_idle();
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
